@@ hdl/ahs_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and codes for the auth handshake sequencer.
// No dependencies; used by ahs_decode and auth_handshake_sequencer.
package ahs_pkg;

  // handshake state codes
  localparam logic [3:0] ST_GREETING      = 4'd0;
  localparam logic [3:0] ST_CLIENT_RESP   = 4'd1;
  localparam logic [3:0] ST_SERVER_AUTH   = 4'd2;
  localparam logic [3:0] ST_CLIENT_SWITCH = 4'd3;
  localparam logic [3:0] ST_SERVER_SWITCH = 4'd4;
  localparam logic [3:0] ST_CLIENT_MORE   = 4'd5;
  localparam logic [3:0] ST_SERVER_MORE   = 4'd6;
  localparam logic [3:0] ST_DONE          = 4'd7;
  localparam logic [3:0] ST_FAILED        = 4'd8;

  // relay actions
  localparam logic [2:0] ACT_TO_CLIENT   = 3'd0;
  localparam logic [2:0] ACT_TO_SERVER   = 3'd1;
  localparam logic [2:0] ACT_COMPLETE    = 3'd2;
  localparam logic [2:0] ACT_RELAY_FAIL  = 3'd3;
  localparam logic [2:0] ACT_SILENT_FAIL = 3'd4;
  localparam logic [2:0] ACT_REJECT      = 3'd5;

  // error codes
  localparam logic [2:0] ERR_NONE           = 3'd0;
  localparam logic [2:0] ERR_EMPTY_GREETING = 3'd1;
  localparam logic [2:0] ERR_ROUND_TRIPS    = 3'd2;
  localparam logic [2:0] ERR_NESTED_SWITCH  = 3'd3;
  localparam logic [2:0] ERR_SWITCH_IN_MORE = 3'd4;
  localparam logic [2:0] ERR_TERMINAL       = 3'd5;

  localparam logic [7:0] MAX_RT_RESET = 8'd10;
  localparam logic [8:0] RT_SAT       = 9'd511;

  typedef struct packed {
    logic [23:0] body_len;
    logic [7:0]  first_byte;
    logic [7:0]  second_byte;
  } ahs_in_t;

  typedef struct packed {
    logic [2:0] action;
    logic [3:0] new_state;
    logic [2:0] fault_code;
  } ahs_out_t;

endpackage

@@ hdl/auth_handshake_sequencer.sv @@
`timescale 1ns / 1ps
// Top level of the auth handshake sequencer: request register, result register,
// handshake state and round-trip counter. Depends on ahs_pkg and ahs_decode.

// Takes one packet descriptor per cycle while not stalled and returns one result
// per request. An accepted request waits in the input register and then moves to
// the result register, which it leaves when the output is not stalled. A single
// decode of state, body length, two bytes and the round-trip compare feeds
// the result register, and the handshake state and round-trip count update in
// the same edge, so the next request sees them at once. The input stalls only
// when both registers hold items and the output is stalled.
// cfg_ready is always high; max_round_trips resets to 10.
module auth_handshake_sequencer (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  ahs_pkg::ahs_in_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output ahs_pkg::ahs_out_t out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [7:0]        cfg_data
);

  logic              req_valid_r, req_valid_nxt;
  ahs_pkg::ahs_in_t  req_r, req_nxt;
  logic              out_valid_r, out_valid_nxt;
  ahs_pkg::ahs_out_t out_data_r, out_data_nxt;
  logic [3:0]        state_r, state_nxt;
  logic [8:0]        rt_count_r, rt_count_nxt;
  logic [7:0]        max_rt_r, max_rt_nxt;

  ahs_pkg::ahs_out_t dec_res;
  logic              dec_rt_inc;
  logic              move;
  logic              take;

  ahs_decode u_decode (
    .req      (req_r),
    .state    (state_r),
    .rt_count (rt_count_r),
    .max_rt   (max_rt_r),
    .res      (dec_res),
    .rt_inc   (dec_rt_inc)
  );

  // request moves to the result register when that slot is free or draining
  assign move     = req_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = req_valid_r && !move;
  assign take     = in_valid && !in_stall;

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    req_valid_nxt = req_valid_r;
    req_nxt       = req_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    state_nxt     = state_r;
    rt_count_nxt  = rt_count_r;
    max_rt_nxt    = max_rt_r;

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
    if (move) begin
      req_valid_nxt = 1'b0;
      out_valid_nxt = 1'b1;
      out_data_nxt  = dec_res;
      state_nxt     = dec_res.new_state;
      if (dec_rt_inc && rt_count_r != ahs_pkg::RT_SAT) begin
        rt_count_nxt = rt_count_r + 9'd1;
      end
    end
    if (take) begin
      req_valid_nxt = 1'b1;
      req_nxt       = in_data;
    end
    if (cfg_valid) begin
      max_rt_nxt = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ahs_pkg::ST_GREETING;
      rt_count_r  <= 9'd0;
      max_rt_r    <= ahs_pkg::MAX_RT_RESET;
    end else begin
      req_valid_r <= req_valid_nxt;
      out_valid_r <= out_valid_nxt;
      state_r     <= state_nxt;
      rt_count_r  <= rt_count_nxt;
      max_rt_r    <= max_rt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r      <= req_nxt;
    out_data_r <= out_data_nxt;
  end

  a_reject_fails: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.action == ahs_pkg::ACT_REJECT)
      |-> out_data_r.new_state == ahs_pkg::ST_FAILED)
    else $error("rejected result does not move to failed");

  a_err_only_on_reject: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_data_r.action != ahs_pkg::ACT_REJECT)
      |-> out_data_r.fault_code == ahs_pkg::ERR_NONE)
    else $error("error code set on a non-rejected result");

  a_state_tracks_result: assert property (@(posedge clk) disable iff (!rst_n)
    move |=> (state_r == out_data_r.new_state && out_valid_r))
    else $error("handshake state differs from last result");

  a_terminal_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    (move && (state_r == ahs_pkg::ST_DONE || state_r == ahs_pkg::ST_FAILED))
      |=> state_r == ahs_pkg::ST_FAILED)
    else $error("left a terminal state");

  a_rt_monotonic: assert property (@(posedge clk) disable iff (!rst_n)
    1'b1 |=> rt_count_r >= $past(rt_count_r))
    else $error("round-trip count went down");

endmodule

@@ hdl/ahs_decode.sv @@
`timescale 1ns / 1ps
// Transition decode: classifies one request against the current state.
// Depends on ahs_pkg for the request/result types and codes.
module ahs_decode (
  input  ahs_pkg::ahs_in_t  req,
  input  logic [3:0]        state,
  input  logic [8:0]        rt_count,
  input  logic [7:0]        max_rt,
  output ahs_pkg::ahs_out_t res,
  output logic              rt_inc
);

  typedef enum logic [2:0] {
    CLS_OK,
    CLS_ERR,
    CLS_EOF,
    CLS_SWITCH,
    CLS_MORE,
    CLS_UNKNOWN
  } cls_t;

  localparam logic [7:0]  PKT_OK        = 8'h00;
  localparam logic [7:0]  PKT_ERR       = 8'hFF;
  localparam logic [7:0]  PKT_EOF       = 8'hFE;
  localparam logic [7:0]  PKT_MORE      = 8'h01;
  localparam logic [7:0]  FAST_OK_MARK  = 8'h03;
  localparam logic [23:0] SWITCH_MINLEN = 24'd9;

  cls_t       cls;
  logic       len_zero;
  logic       fast;
  logic       limit;
  logic [2:0] act;
  logic [3:0] nxt;
  logic [2:0] err;

  assign len_zero = (req.body_len == 24'd0);
  assign fast     = (|req.body_len[23:1]) && (req.second_byte == FAST_OK_MARK);
  assign limit    = (rt_count >= {1'b0, max_rt});

  always_comb begin
    if (len_zero) begin
      cls = CLS_UNKNOWN;
    end else begin
      case (req.first_byte)
        PKT_OK:   cls = CLS_OK;
        PKT_ERR:  cls = CLS_ERR;
        PKT_EOF:  cls = (req.body_len < SWITCH_MINLEN) ? CLS_EOF : CLS_SWITCH;
        PKT_MORE: cls = CLS_MORE;
        default:  cls = CLS_UNKNOWN;
      endcase
    end
  end

  always_comb begin
    act = ahs_pkg::ACT_REJECT;
    nxt = ahs_pkg::ST_FAILED;
    err = ahs_pkg::ERR_TERMINAL;
    case (state)
      ahs_pkg::ST_GREETING: begin
        if (len_zero) begin
          err = ahs_pkg::ERR_EMPTY_GREETING;
        end else begin
          act = ahs_pkg::ACT_TO_CLIENT;
          nxt = ahs_pkg::ST_CLIENT_RESP;
          err = ahs_pkg::ERR_NONE;
        end
      end
      ahs_pkg::ST_CLIENT_RESP: begin
        act = ahs_pkg::ACT_TO_SERVER;
        nxt = ahs_pkg::ST_SERVER_AUTH;
        err = ahs_pkg::ERR_NONE;
      end
      ahs_pkg::ST_CLIENT_SWITCH: begin
        act = ahs_pkg::ACT_TO_SERVER;
        nxt = ahs_pkg::ST_SERVER_SWITCH;
        err = ahs_pkg::ERR_NONE;
      end
      ahs_pkg::ST_CLIENT_MORE: begin
        act = ahs_pkg::ACT_TO_SERVER;
        nxt = ahs_pkg::ST_SERVER_MORE;
        err = ahs_pkg::ERR_NONE;
      end
      ahs_pkg::ST_SERVER_AUTH, ahs_pkg::ST_SERVER_SWITCH, ahs_pkg::ST_SERVER_MORE: begin
        err = ahs_pkg::ERR_NONE;
        case (cls)
          CLS_OK: begin
            act = ahs_pkg::ACT_COMPLETE;
            nxt = ahs_pkg::ST_DONE;
          end
          CLS_ERR, CLS_EOF: begin
            act = ahs_pkg::ACT_RELAY_FAIL;
          end
          CLS_SWITCH: begin
            if (state == ahs_pkg::ST_SERVER_AUTH) begin
              act = ahs_pkg::ACT_TO_CLIENT;
              nxt = ahs_pkg::ST_CLIENT_SWITCH;
            end else if (state == ahs_pkg::ST_SERVER_SWITCH) begin
              err = ahs_pkg::ERR_NESTED_SWITCH;
            end else begin
              err = ahs_pkg::ERR_SWITCH_IN_MORE;
            end
          end
          CLS_MORE: begin
            if (state != ahs_pkg::ST_SERVER_AUTH && limit) begin
              err = ahs_pkg::ERR_ROUND_TRIPS;
            end else begin
              act = ahs_pkg::ACT_TO_CLIENT;
              // fast auth keeps waiting on the server, except after a switch
              if (state == ahs_pkg::ST_SERVER_SWITCH || !fast) begin
                nxt = ahs_pkg::ST_CLIENT_MORE;
              end else begin
                nxt = ahs_pkg::ST_SERVER_MORE;
              end
            end
          end
          default: begin
            if (state != ahs_pkg::ST_SERVER_MORE) begin
              act = ahs_pkg::ACT_SILENT_FAIL;
            end else if (limit) begin
              err = ahs_pkg::ERR_ROUND_TRIPS;
            end else begin
              act = ahs_pkg::ACT_TO_CLIENT;
              nxt = ahs_pkg::ST_CLIENT_MORE;
            end
          end
        endcase
      end
      // done, failed and unused codes are terminal
      default: begin
        act = ahs_pkg::ACT_REJECT;
      end
    endcase
  end

  assign res.action     = act;
  assign res.new_state  = nxt;
  assign res.fault_code = err;
  assign rt_inc = (act != ahs_pkg::ACT_REJECT) &&
                  (nxt inside {ahs_pkg::ST_CLIENT_MORE, ahs_pkg::ST_CLIENT_SWITCH});

endmodule
